FILE: hdl/bucket_sorted_degree_order_top_assert.svh
// Assertion macros shared by the degree order block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef BUCKET_SORTED_DEGREE_ORDER_TOP_ASSERT_SVH
`define BUCKET_SORTED_DEGREE_ORDER_TOP_ASSERT_SVH

// Same-cycle implication.
`define BSDO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSDO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bsdo_pkg.sv
// Package for the degree order block: widths, payload types, step names and
// the microcode table. No dependencies.
package bsdo_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int MAX_DEGREE = 255;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int BS_DEPTH   = MAX_DEGREE + 1;
    localparam int BS_W       = $clog2(NODE_COUNT + 1);
    localparam int TOPC_W     = 11;
    localparam int SUM_W      = 18;
    localparam int STEP_W     = 4;

    typedef struct packed {
        logic              kind;
        logic [NODE_W-1:0] node;
    } t_in;

    typedef struct packed {
        logic [NODE_W-1:0] top_node;
        logic [DEG_W-1:0]  max_degree;
        logic [SUM_W-1:0]  top_sum;
        logic              bad_request;
    } t_out;

    typedef enum logic [STEP_W-1:0] {
        ST_IDLE,
        ST_RDDEG,
        ST_CHECK,
        ST_RDNAP,
        ST_WRA,
        ST_WRB,
        ST_RDTOP,
        ST_RDTDEG,
        ST_EMIT,
        ST_CLEAR
    } t_step;

    typedef enum logic [1:0] {
        W_NONE,
        W_CLEAR,
        W_A,
        W_B
    } t_wsel;

    typedef enum logic [2:0] {
        J_NEXT,
        J_WAIT,
        J_BAD,
        J_CLEAR,
        J_GOTO
    } t_jump;

    typedef struct packed {
        logic  latch_dp;
        logic  latch_s;
        logic  upd_sum;
        t_wsel wsel;
        logic  nap_rd_q;
        logic  deg_rd_top;
        logic  latch_top;
        logic  emit;
        t_jump jump;
        t_step target;
    } t_ctl;

    typedef struct packed {
        t_ctl              ctl;
        logic              accept;
        logic [NODE_W-1:0] clr_idx;
    } t_drv;

    function automatic t_ctl ucode(t_step s);
        t_ctl c;
        c = '{latch_dp: 1'b0, latch_s: 1'b0, upd_sum: 1'b0, wsel: W_NONE,
              nap_rd_q: 1'b0, deg_rd_top: 1'b0, latch_top: 1'b0, emit: 1'b0,
              jump: J_NEXT, target: ST_IDLE};
        case (s)
            ST_IDLE:   c.jump = J_WAIT;
            ST_RDDEG:  c.jump = J_NEXT;
            ST_CHECK: begin
                c.latch_dp = 1'b1;
                c.jump     = J_BAD;
                c.target   = ST_RDTOP;
            end
            ST_RDNAP: begin
                c.latch_s  = 1'b1;
                c.upd_sum  = 1'b1;
                c.nap_rd_q = 1'b1;
            end
            ST_WRA:    c.wsel = W_A;
            ST_WRB:    c.wsel = W_B;
            ST_RDTOP:  c.jump = J_NEXT;
            ST_RDTDEG: begin
                c.deg_rd_top = 1'b1;
                c.latch_top  = 1'b1;
            end
            ST_EMIT: begin
                c.emit   = 1'b1;
                c.jump   = J_GOTO;
                c.target = ST_IDLE;
            end
            ST_CLEAR: begin
                c.wsel   = W_CLEAR;
                c.jump   = J_CLEAR;
                c.target = ST_IDLE;
            end
            default: begin
                c.jump   = J_GOTO;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/bsdo_ram.sv
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module bsdo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bsdo_seq.sv
// Microcode sequencer: step register, control table lookup, jumps and the
// clear-pass counter. Depends on bsdo_pkg and the assertion macro header.
`include "bucket_sorted_degree_order_top_assert.svh"

module bsdo_seq import bsdo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic i_bad,
    output logic busy,
    output t_drv o_drv
);

    t_step             r_step, n_step;
    logic [NODE_W-1:0] r_clr, n_clr;
    t_ctl              ctl;
    logic              clr_last;
    logic              accept;

    assign ctl      = ucode(r_step);
    assign clr_last = (r_clr == NODE_W'(NODE_COUNT - 1));
    assign accept   = (r_step == ST_IDLE) && start;
    assign busy     = (r_step != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CLEAR;
            r_clr  <= '0;
        end else begin
            r_step <= n_step;
            r_clr  <= n_clr;
        end
    end

    always_comb begin
        t_step step_inc;
        step_inc = t_step'(r_step + STEP_W'(1));
        n_step   = step_inc;
        n_clr    = r_clr;
        case (ctl.jump)
            J_NEXT: n_step = step_inc;
            J_WAIT: n_step = start ? step_inc : r_step;
            J_BAD:  n_step = i_bad ? ctl.target : step_inc;
            J_CLEAR: begin
                n_clr  = r_clr + NODE_W'(1);
                n_step = clr_last ? ctl.target : r_step;
            end
            J_GOTO: n_step = ctl.target;
            default: n_step = ST_IDLE;
        endcase
    end

    assign o_drv = '{ctl: ctl, accept: accept, clr_idx: r_clr};

    `BSDO_ASSERT_NEXT(a_emit_to_idle, r_step == ST_EMIT, r_step == ST_IDLE, "emit must return to idle")
    `BSDO_ASSERT_NEXT(a_clear_holds, (r_step == ST_CLEAR) && !clr_last, r_step == ST_CLEAR, "clear pass ended early")
    `BSDO_ASSERT_NEXT(a_accept_runs, accept, r_step == ST_RDDEG, "accepted transaction did not start")

endmodule

FILE: hdl/bsdo_dp.sv
// Datapath: degree, position and bucket tables, exchange logic, running
// top-k sum and result register. Depends on bsdo_pkg, bsdo_ram, macro header.
`include "bucket_sorted_degree_order_top_assert.svh"

module bsdo_dp import bsdo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_drv              i_drv,
    input  t_in               i_item,
    input  logic              i_cfg_we,
    input  logic [TOPC_W-1:0] i_cfg_data,
    output logic              o_bad,
    output logic              o_done,
    output t_out              o_result
);

    localparam int BS_AW = $clog2(BS_DEPTH);

    t_ctl ctl;
    assign ctl = i_drv.ctl;

    logic              r_kind;
    logic [NODE_W-1:0] r_node;
    logic [DEG_W-1:0]  r_deg;
    logic [NODE_W-1:0] r_pos;
    logic [BS_AW-1:0]  r_bidx;
    logic              r_bad;
    logic [BS_W-1:0]   r_s;
    logic [NODE_W-1:0] r_q;
    logic [NODE_W-1:0] r_b;
    logic [NODE_W-1:0] r_top;
    logic [SUM_W-1:0]  r_sum;
    logic [TOPC_W-1:0] r_top_count;
    logic              r_done;
    t_out              r_res;

    logic [DEG_W-1:0]  deg_rdata;
    logic [NODE_W-1:0] pon_rdata;
    logic [NODE_W-1:0] nap_rdata;
    logic [BS_W-1:0]   bs_rdata;

    logic [BS_AW-1:0]  bidx;
    logic              bad;
    logic [NODE_W-1:0] q;
    logic              q_in_top;

    logic              deg_we, pon_we, nap_we, bs_we;
    logic [NODE_W-1:0] deg_waddr, pon_waddr, nap_waddr;
    logic [DEG_W-1:0]  deg_wdata;
    logic [NODE_W-1:0] pon_wdata, nap_wdata;
    logic [BS_AW-1:0]  bs_waddr;
    logic [BS_W-1:0]   bs_wdata;
    logic [NODE_W-1:0] deg_raddr, nap_raddr;

    // Lower uses the bucket of d, raise the bucket of d+1.
    assign bidx = r_kind ? BS_AW'(deg_rdata) : BS_AW'(deg_rdata + DEG_W'(1));
    assign bad  = r_kind ? (deg_rdata == '0) : (deg_rdata >= DEG_W'(MAX_DEGREE));

    // Exchange partner: last slot below bucket d+1, or first slot of bucket d.
    always_comb begin
        if (!r_kind) begin
            q = (bs_rdata != '0) ? NODE_W'(bs_rdata - BS_W'(1)) : r_pos;
        end else begin
            q = (bs_rdata < BS_W'(NODE_COUNT)) ? NODE_W'(bs_rdata) : r_pos;
        end
    end

    assign q_in_top = ({2'b00, q} + {1'b0, r_top_count}) >= (NODE_W + 2)'(NODE_COUNT);

    assign deg_raddr = ctl.deg_rd_top ? nap_rdata : r_node;
    assign nap_raddr = ctl.nap_rd_q ? q : NODE_W'(NODE_COUNT - 1);

    always_comb begin
        deg_we    = 1'b0;
        deg_waddr = r_node;
        deg_wdata = r_kind ? (r_deg - DEG_W'(1)) : (r_deg + DEG_W'(1));
        pon_we    = 1'b0;
        pon_waddr = r_node;
        pon_wdata = r_q;
        nap_we    = 1'b0;
        nap_waddr = r_pos;
        nap_wdata = nap_rdata;
        bs_we     = 1'b0;
        bs_waddr  = r_bidx;
        bs_wdata  = r_kind ? (r_s + BS_W'(1)) : (r_s - BS_W'(1));
        case (ctl.wsel)
            W_CLEAR: begin
                deg_we    = 1'b1;
                deg_waddr = i_drv.clr_idx;
                deg_wdata = '0;
                pon_we    = 1'b1;
                pon_waddr = i_drv.clr_idx;
                pon_wdata = i_drv.clr_idx;
                nap_we    = 1'b1;
                nap_waddr = i_drv.clr_idx;
                nap_wdata = i_drv.clr_idx;
                bs_we     = ({1'b0, i_drv.clr_idx} < (NODE_W + 1)'(BS_DEPTH));
                bs_waddr  = i_drv.clr_idx[BS_AW-1:0];
                bs_wdata  = (i_drv.clr_idx == '0) ? '0 : BS_W'(NODE_COUNT);
            end
            W_A: begin
                // p <- b, pos(t) <- q, degree and bucket start move
                deg_we = 1'b1;
                pon_we = 1'b1;
                nap_we = 1'b1;
                bs_we  = r_kind ? (r_s < BS_W'(NODE_COUNT)) : (r_s != '0);
            end
            W_B: begin
                // q <- t, pos(b) <- p; harmless when p == q
                nap_we    = 1'b1;
                nap_waddr = r_q;
                nap_wdata = r_node;
                pon_we    = 1'b1;
                pon_waddr = r_b;
                pon_wdata = r_pos;
            end
            default: ;
        endcase
    end

    bsdo_ram #(.WIDTH(DEG_W), .DEPTH(NODE_COUNT)) u_deg (
        .i_clk(i_clk), .i_we(deg_we), .i_waddr(deg_waddr), .i_wdata(deg_wdata),
        .i_raddr(deg_raddr), .o_rdata(deg_rdata)
    );

    bsdo_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_pon (
        .i_clk(i_clk), .i_we(pon_we), .i_waddr(pon_waddr), .i_wdata(pon_wdata),
        .i_raddr(r_node), .o_rdata(pon_rdata)
    );

    bsdo_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_nap (
        .i_clk(i_clk), .i_we(nap_we), .i_waddr(nap_waddr), .i_wdata(nap_wdata),
        .i_raddr(nap_raddr), .o_rdata(nap_rdata)
    );

    bsdo_ram #(.WIDTH(BS_W), .DEPTH(BS_DEPTH)) u_bs (
        .i_clk(i_clk), .i_we(bs_we), .i_waddr(bs_waddr), .i_wdata(bs_wdata),
        .i_raddr(bidx), .o_rdata(bs_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_drv.accept) begin
            r_kind <= i_item.kind;
            r_node <= i_item.node;
        end
        if (ctl.latch_dp) begin
            r_deg  <= deg_rdata;
            r_pos  <= pon_rdata;
            r_bidx <= bidx;
            r_bad  <= bad;
        end
        if (ctl.latch_s) begin
            r_s <= bs_rdata;
            r_q <= q;
        end
        if (ctl.wsel == W_A) begin
            r_b <= nap_rdata;
        end
        if (ctl.latch_top) begin
            r_top <= nap_rdata;
        end
        if (ctl.emit) begin
            r_res <= '{top_node: r_top, max_degree: deg_rdata, top_sum: r_sum,
                       bad_request: r_bad};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_top_count <= TOPC_W'(1);
            r_done      <= 1'b0;
        end else begin
            r_done <= ctl.emit;
            if (i_cfg_we) begin
                r_top_count <= i_cfg_data;
            end
            // new slot of t after a raise, vacated slot q after a lower
            if (ctl.upd_sum && q_in_top) begin
                r_sum <= r_kind ? (r_sum - SUM_W'(1)) : (r_sum + SUM_W'(1));
            end
        end
    end

    assign o_bad    = bad;
    assign o_done   = r_done;
    assign o_result = r_res;

    `BSDO_ASSERT_NEXT(a_done_after_emit, ctl.emit, r_done, "result strobe missing after emit step")
    `BSDO_ASSERT_NEXT(a_sum_stable, !ctl.upd_sum, $stable(r_sum), "top sum moved outside update step")

endmodule

FILE: hdl/bucket_sorted_degree_order_top.sv
// Top level of the bucket-sorted degree order block: sequencer plus datapath.
// Depends on bsdo_pkg, bsdo_seq, bsdo_dp (and bsdo_ram below it).
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+--------------------------------
//  item in  | i_item (t_in)            | start high while busy low
//  result   | o_result (t_out)         | o_done high for one cycle
//  config   | i_cfg_data (top_count)   | i_cfg_we high, no wait
//
// A transaction runs steps RDDEG, CHECK, RDNAP, WRA, WRB, RDTOP, RDTDEG and EMIT
// after its accept edge, a chain of registered table reads (degree, bucket start,
// boundary node, top node, top degree); a refused request skips the exchange. The
// result is on o_result in the cycle after EMIT, with busy low, and only then is
// a new item taken. After reset a clearing pass sets up the tables with busy high.
// The result side cannot stall; config writes are taken at any time.
module bucket_sorted_degree_order_top import bsdo_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  t_in               i_item,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [TOPC_W-1:0] i_cfg_data,
    output logic              o_done,
    output t_out              o_result
);

    t_drv drv;
    logic bad;

    bsdo_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_bad   (bad),
        .busy    (busy),
        .o_drv   (drv)
    );

    bsdo_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_drv      (drv),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_bad      (bad),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

FILE: dv/tb_bucket_sorted_degree_order_top.sv
`timescale 1ns / 100ps
// Testbench for bucket_sorted_degree_order_top: a scoreboard class that tracks the
// degree ordering, and tasks that drive items and top_count writes. Depends on bsdo_pkg.
import bsdo_pkg::*;

localparam logic KIND_RAISE = 1'b0;
localparam logic KIND_LOWER = 1'b1;

class degree_order_scoreboard;
    logic [DEG_W-1:0]  node_deg  [NODE_COUNT];
    logic [NODE_W-1:0] node_at   [NODE_COUNT];
    logic [NODE_W-1:0] pos_of    [NODE_COUNT];
    logic [BS_W-1:0]   bucket_lo [BS_DEPTH];
    logic [SUM_W-1:0]  top_sum;
    logic [TOPC_W-1:0] top_count;
    t_out              expected_q[$];
    int                errors;

    function new();
        for (int i = 0; i < NODE_COUNT; i++) begin
            node_deg[i] = '0;
            node_at[i]  = NODE_W'(i);
            pos_of[i]   = NODE_W'(i);
        end
        bucket_lo[0] = '0;
        for (int i = 1; i < BS_DEPTH; i++) bucket_lo[i] = BS_W'(NODE_COUNT);
        top_sum   = '0;
        top_count = TOPC_W'(1);
        errors    = 0;
    endfunction

    function void set_top_count(logic [TOPC_W-1:0] v);
        top_count = v;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function bit in_top(int pos);
        return (pos + int'(top_count)) >= NODE_COUNT;
    endfunction

    function void swap_positions(int p, int q);
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        if (p == q) return;
        a = node_at[p];
        b = node_at[q];
        node_at[p] = b;
        node_at[q] = a;
        pos_of[a]  = NODE_W'(q);
        pos_of[b]  = NODE_W'(p);
    endfunction

    // Unless refused, moves the node across its bucket's edge, then shifts that edge.
    function void note_item(t_in it);
        int   d;
        int   s;
        int   q;
        int   t;
        t_out exp_res;
        logic bad;
        t   = int'(it.node);
        d   = int'(node_deg[t]);
        bad = 1'b0;
        if (it.kind == KIND_RAISE) begin
            if (d >= MAX_DEGREE) begin
                bad = 1'b1;
            end else begin
                s = int'(bucket_lo[d+1]);
                q = (s > 0) ? s - 1 : int'(pos_of[t]);
                swap_positions(int'(pos_of[t]), q);
                if (s > 0) bucket_lo[d+1] = BS_W'(s - 1);
                node_deg[t] = DEG_W'(d + 1);
                if (in_top(int'(pos_of[t]))) top_sum = top_sum + 1'b1;
            end
        end else begin
            if (d == 0) begin
                bad = 1'b1;
            end else begin
                s = int'(bucket_lo[d]);
                q = (s < NODE_COUNT) ? s : int'(pos_of[t]);
                // the sum loses the degree at the boundary slot before the exchange
                if (in_top(q)) top_sum = top_sum - 1'b1;
                swap_positions(int'(pos_of[t]), q);
                if (s < NODE_COUNT) bucket_lo[d] = BS_W'(s + 1);
                node_deg[t] = DEG_W'(d - 1);
            end
        end
        exp_res.top_node    = node_at[NODE_COUNT-1];
        exp_res.max_degree  = node_deg[node_at[NODE_COUNT-1]];
        exp_res.top_sum     = top_sum;
        exp_res.bad_request = bad;
        expected_q.push_back(exp_res);
    endfunction

    task report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task check_result(t_out got);
        t_out want;
        if (expected_q.size() == 0) begin
            report("unexpected result, top_node", int'(got.top_node), -1);
            return;
        end
        want = expected_q.pop_front();
        if (got.top_node != want.top_node)
            report("top_node", int'(got.top_node), int'(want.top_node));
        if (got.max_degree != want.max_degree)
            report("max_degree", int'(got.max_degree), int'(want.max_degree));
        if (got.top_sum != want.top_sum)
            report("top_sum", int'(got.top_sum), int'(want.top_sum));
        if (got.bad_request != want.bad_request)
            report("bad_request", int'(got.bad_request), int'(want.bad_request));
    endtask
endclass

module tb_bucket_sorted_degree_order_top;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    t_in               i_item;
    logic              busy;
    logic              i_cfg_we;
    logic [TOPC_W-1:0] i_cfg_data;
    logic              o_done;
    t_out              o_result;

    degree_order_scoreboard sb;
    int hot_nodes [8];

    bucket_sorted_degree_order_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_result(o_result);
            if (i_cfg_we) sb.set_top_count(i_cfg_data);
            if (start && !busy) sb.note_item(i_item);
        end
    end

    // Returns at the edge that accepts the transaction; start stays high.
    task send_item(logic k, logic [NODE_W-1:0] n);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= t_in'{kind: k, node: n};
        do @(posedge i_clk); while (busy);
    endtask

    task idle_for(int n);
        @(negedge i_clk);
        start  <= 1'b0;
        i_item <= t_in'($urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    task maybe_idle(bit allow);
        if (allow && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 18));
    endtask

    task drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task write_top_count(logic [TOPC_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= TOPC_W'($urandom);
    endtask

    // Mostly a few hot nodes so degrees climb and buckets fill; the rest is scatter.
    task run_random(int count, bit allow);
        int  r;
        logic k;
        logic [NODE_W-1:0] n;
        bit  quiet;
        quiet = 1'b0;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                n = NODE_W'(hot_nodes[$urandom_range(0, 7)]);
                k = ($urandom_range(0, 99) < 58) ? KIND_RAISE : KIND_LOWER;
            end else if (r < 90) begin
                n = NODE_W'($urandom);
                k = KIND_RAISE;
            end else begin
                n = NODE_W'($urandom);
                k = $urandom_range(0, 1) ? KIND_LOWER : KIND_RAISE;
            end
            send_item(k, n);
            if ($urandom_range(0, 29) == 0) quiet = !quiet;
            maybe_idle(allow && !quiet);
        end
    endtask

    initial begin
        logic [TOPC_W-1:0] settings [6];
        int hammer;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        sb = new();
        hot_nodes[0] = 0;
        hot_nodes[1] = NODE_COUNT - 1;
        for (int i = 2; i < 8; i++) hot_nodes[i] = $urandom_range(0, NODE_COUNT - 1);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lower at zero, bucket edges, top_count extremes
        send_item(KIND_LOWER, NODE_W'(0));
        send_item(KIND_RAISE, NODE_W'(0));
        maybe_idle(1'b1);
        send_item(KIND_RAISE, NODE_W'(0));
        send_item(KIND_RAISE, NODE_W'(1023));
        send_item(KIND_RAISE, NODE_W'(1023));
        maybe_idle(1'b1);
        send_item(KIND_RAISE, NODE_W'(1023));
        send_item(KIND_RAISE, NODE_W'(512));
        send_item(KIND_LOWER, NODE_W'(1023));
        send_item(KIND_LOWER, NODE_W'(0));
        send_item(KIND_LOWER, NODE_W'(0));
        send_item(KIND_LOWER, NODE_W'(0));
        write_top_count(TOPC_W'(0));
        send_item(KIND_RAISE, NODE_W'(5));
        send_item(KIND_LOWER, NODE_W'(5));
        write_top_count(TOPC_W'(2047));
        send_item(KIND_RAISE, NODE_W'(1));
        send_item(KIND_RAISE, NODE_W'(2));
        send_item(KIND_RAISE, NODE_W'(1));
        send_item(KIND_LOWER, NODE_W'(2));
        send_item(KIND_LOWER, NODE_W'(2));
        send_item(KIND_LOWER, NODE_W'(1));
        write_top_count(TOPC_W'(1024));
        send_item(KIND_RAISE, NODE_W'(1023));
        send_item(KIND_LOWER, NODE_W'(1023));

        // one node driven past the top degree and back below zero
        hammer = $urandom_range(0, NODE_COUNT - 1);
        for (int i = 0; i < MAX_DEGREE + 2; i++) begin
            send_item(KIND_RAISE, NODE_W'(hammer));
            maybe_idle(i % 64 < 32);
        end
        for (int i = 0; i < MAX_DEGREE + 2; i++) begin
            send_item(KIND_LOWER, NODE_W'(hammer));
            maybe_idle(i % 64 >= 32);
        end

        settings[0] = TOPC_W'(1);
        settings[1] = TOPC_W'(0);
        settings[2] = TOPC_W'($urandom_range(2, 8));
        settings[3] = TOPC_W'(1023);
        settings[4] = TOPC_W'(2047);
        settings[5] = TOPC_W'($urandom);
        for (int p = 0; p < 6; p++) begin
            write_top_count(settings[p]);
            run_random(75, 1'b1);
        end
        // top_count changed mid-stream without recomputing the sum
        write_top_count(TOPC_W'($urandom_range(0, 40)));
        run_random(60, 1'b1);
        run_random(60, 1'b0);

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/bsdo_pkg.sv
hdl/bsdo_ram.sv
hdl/bsdo_seq.sv
hdl/bsdo_dp.sv
hdl/bucket_sorted_degree_order_top.sv
dv/tb_bucket_sorted_degree_order_top.sv
